@@ sv/i2c_master_register_access_assert.svh @@
// Assertion macros used by the I2C master register access sequencer
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/i2cm_pkg.sv @@
// Types and constants for the I2C master register access block
`timescale 1ns / 1ps

package i2cm_pkg;

    // Input word selector codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Status codes
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_BUSY = 2'd1;
    localparam logic [1:0] ERR_BUS  = 2'd2;
    localparam logic [1:0] ERR_NACK = 2'd3;

    // Which byte a send block is moving
    localparam logic [1:0] BYTE_DEV    = 2'd0;
    localparam logic [1:0] BYTE_REG    = 2'd1;
    localparam logic [1:0] BYTE_DATA   = 2'd2;
    localparam logic [1:0] BYTE_DEV_RD = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
    localparam logic [7:0] DEV_READ_INC    = 8'h01;
    localparam logic [9:0] PHASE_TICKS_RST = 10'd100;

    // Config register map
    localparam logic [1:0] ADDR_PHASE_TICKS = 2'd0;

    // Input word
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic [1:0] status;
        logic       cmd_rejected;
    } t_out_word;

    // Classified operation
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Queue entry
    typedef struct packed {
        t_op        op;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_qent;

    // Queue head as seen by the sequencer
    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qhead;

    // Sequencer phase groups
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_SEND  = 6'b000100,
        ST_RECV  = 6'b001000,
        ST_NACK  = 6'b010000,
        ST_STOP  = 6'b100000
    } t_state;

endpackage

@@ sv/i2cm_front.sv @@
// Front end: classifies incoming words and queues them for the sequencer
`timescale 1ns / 1ps

module i2cm_front #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  i2cm_pkg::t_in_word i_in_word,
    output i2cm_pkg::t_qhead   o_head,
    input  logic               i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    i2cm_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_rp, n_rp;
    logic [CW-1:0]   r_count, n_count;
    i2cm_pkg::t_qent cls;
    logic            push;

    // Classify the selector
    always_comb begin
        cls.dev_addr = i_in_word.dev_addr;
        cls.reg_addr = i_in_word.reg_addr;
        cls.wr_data  = i_in_word.wr_data;
        cls.sda_in   = i_in_word.sda_in;
        unique case (i_in_word.func)
            i2cm_pkg::FUNC_TICK:  cls.op = i2cm_pkg::OP_TICK;
            i2cm_pkg::FUNC_WRITE: cls.op = i2cm_pkg::OP_WRITE;
            i2cm_pkg::FUNC_READ:  cls.op = i2cm_pkg::OP_READ;
            default:              cls.op = i2cm_pkg::OP_NOP;
        endcase
    end

    assign o_in_stall = (r_count == CW'(DEPTH));
    assign push       = i_in_valid && !o_in_stall;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.ent   = r_mem[r_rp];

endmodule

@@ sv/i2cm_seq.sv @@
// Back end: bus phase sequencer and result register
`timescale 1ns / 1ps
`include "i2c_master_register_access_assert.svh"

module i2cm_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2cm_pkg::t_qhead    i_head,
    output logic                o_pop,
    input  logic [9:0]          i_phase_ticks,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cm_pkg::t_out_word o_out_word
);

    i2cm_pkg::t_state    r_state, n_state;
    logic [2:0]          r_sub, n_sub;
    logic                r_rep, n_rep;
    logic [1:0]          r_byte, n_byte;
    logic [3:0]          r_bit, n_bit;
    logic [7:0]          r_shift, n_shift;
    logic [9:0]          r_wait, n_wait;
    logic [1:0]          r_err, n_err;
    logic [7:0]          r_rxd, n_rxd;
    logic                r_is_read, n_is_read;
    logic [7:0]          r_dev, n_dev;
    logic [7:0]          r_reg, n_reg;
    logic [7:0]          r_data, n_data;
    logic                r_scl, n_scl;
    logic                r_sda, n_sda;
    logic                r_out_valid;
    i2cm_pkg::t_out_word r_out;

    i2cm_pkg::t_qent     ent;
    logic [9:0]          limit;
    logic [9:0]          wait_inc;
    logic [3:0]          bit_inc;
    logic [7:0]          sh;
    logic                done;
    logic                rej;

    assign ent      = i_head.ent;
    assign o_pop    = i_head.valid && (!r_out_valid || !i_out_stall);
    assign limit    = (i_phase_ticks == '0) ? 10'd1 : i_phase_ticks;
    assign wait_inc = r_wait + 10'd1;
    assign bit_inc  = r_bit + 4'd1;

    // Next state for the word at the queue head
    always_comb begin
        n_state   = r_state;
        n_sub     = r_sub;
        n_rep     = r_rep;
        n_byte    = r_byte;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_wait    = r_wait;
        n_err     = r_err;
        n_rxd     = r_rxd;
        n_is_read = r_is_read;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_data    = r_data;
        n_scl     = r_scl;
        n_sda     = r_sda;
        sh        = '0;
        done      = 1'b0;
        rej       = 1'b0;

        unique case (ent.op)
            i2cm_pkg::OP_TICK: begin
                if (r_state != i2cm_pkg::ST_IDLE) begin
                    n_wait = wait_inc;
                    if (wait_inc >= limit) begin
                        n_wait = '0;
                        unique case (r_state)
                            // start or repeated start
                            i2cm_pkg::ST_START: begin
                                unique case (r_sub)
                                    3'd0: begin
                                        n_sub = 3'd1;
                                        n_scl = 1'b1;
                                    end
                                    3'd1: begin
                                        if (!ent.sda_in && r_err == i2cm_pkg::ERR_OK) begin
                                            n_err = i2cm_pkg::ERR_BUSY;
                                        end
                                        n_sub = 3'd2;
                                        n_sda = 1'b0;
                                    end
                                    3'd2: begin
                                        n_sub = 3'd3;
                                        n_scl = 1'b0;
                                    end
                                    default: begin
                                        if (ent.sda_in && r_err == i2cm_pkg::ERR_OK) begin
                                            n_err = i2cm_pkg::ERR_BUS;
                                        end
                                        sh      = r_rep ? r_dev + i2cm_pkg::DEV_READ_INC : r_dev;
                                        n_shift = sh;
                                        n_bit   = '0;
                                        n_state = i2cm_pkg::ST_SEND;
                                        n_sub   = 3'd0;
                                        n_byte  = r_rep ? i2cm_pkg::BYTE_DEV_RD
                                                        : i2cm_pkg::BYTE_DEV;
                                        n_scl   = 1'b0;
                                        n_sda   = sh[7];
                                    end
                                endcase
                            end
                            // one byte out, then the ack slot
                            i2cm_pkg::ST_SEND: begin
                                unique case (r_sub)
                                    3'd0: begin
                                        n_sub = 3'd1;
                                        n_scl = 1'b1;
                                    end
                                    3'd1: begin
                                        n_sub = 3'd2;
                                        n_scl = 1'b0;
                                    end
                                    3'd2: begin
                                        sh      = {r_shift[6:0], 1'b0};
                                        n_shift = sh;
                                        n_bit   = bit_inc;
                                        if (bit_inc < i2cm_pkg::BITS_PER_BYTE) begin
                                            n_sub = 3'd0;
                                            n_scl = 1'b0;
                                            n_sda = sh[7];
                                        end else begin
                                            n_sub = 3'd3;
                                            n_sda = 1'b1;
                                        end
                                    end
                                    3'd3: begin
                                        n_sub = 3'd4;
                                        n_scl = 1'b1;
                                    end
                                    default: begin
                                        if (ent.sda_in && r_err == i2cm_pkg::ERR_OK) begin
                                            n_err = i2cm_pkg::ERR_NACK;
                                        end
                                        n_scl = 1'b0;
                                        n_bit = '0;
                                        n_sub = 3'd0;
                                        unique case (r_byte)
                                            i2cm_pkg::BYTE_DEV: begin
                                                n_shift = r_reg;
                                                n_byte  = i2cm_pkg::BYTE_REG;
                                                n_sda   = r_reg[7];
                                            end
                                            i2cm_pkg::BYTE_REG: begin
                                                if (r_is_read) begin
                                                    n_state = i2cm_pkg::ST_START;
                                                    n_rep   = 1'b1;
                                                    n_sda   = 1'b1;
                                                end else begin
                                                    n_shift = r_data;
                                                    n_byte  = i2cm_pkg::BYTE_DATA;
                                                    n_sda   = r_data[7];
                                                end
                                            end
                                            i2cm_pkg::BYTE_DATA: begin
                                                n_state = i2cm_pkg::ST_STOP;
                                                n_sda   = 1'b0;
                                            end
                                            default: begin
                                                n_shift = '0;
                                                n_state = i2cm_pkg::ST_RECV;
                                                n_sda   = 1'b1;
                                                n_scl   = 1'b1;
                                            end
                                        endcase
                                    end
                                endcase
                            end
                            // receive one bit per clock pulse
                            i2cm_pkg::ST_RECV: begin
                                if (r_sub == 3'd0) begin
                                    n_shift = {r_shift[6:0], ent.sda_in};
                                    n_sub   = 3'd1;
                                    n_scl   = 1'b0;
                                end else begin
                                    n_bit = bit_inc;
                                    if (bit_inc < i2cm_pkg::BITS_PER_BYTE) begin
                                        n_sub = 3'd0;
                                        n_sda = 1'b1;
                                        n_scl = 1'b1;
                                    end else begin
                                        n_rxd   = r_shift;
                                        n_state = i2cm_pkg::ST_NACK;
                                        n_sub   = 3'd0;
                                        n_sda   = 1'b1;
                                    end
                                end
                            end
                            // released-SDA ack bit after the read byte
                            i2cm_pkg::ST_NACK: begin
                                unique case (r_sub)
                                    3'd0: begin
                                        n_sub = 3'd1;
                                        n_scl = 1'b1;
                                    end
                                    3'd1: begin
                                        n_sub = 3'd2;
                                        n_scl = 1'b0;
                                    end
                                    default: begin
                                        n_state = i2cm_pkg::ST_STOP;
                                        n_sub   = 3'd0;
                                        n_sda   = 1'b0;
                                    end
                                endcase
                            end
                            // stop condition
                            i2cm_pkg::ST_STOP: begin
                                unique case (r_sub)
                                    3'd0: begin
                                        n_sub = 3'd1;
                                        n_scl = 1'b1;
                                    end
                                    3'd1: begin
                                        n_sub = 3'd2;
                                        n_sda = 1'b1;
                                    end
                                    default: begin
                                        n_state = i2cm_pkg::ST_IDLE;
                                        n_sub   = 3'd0;
                                        done    = 1'b1;
                                    end
                                endcase
                            end
                            default: ;
                        endcase
                    end
                end
            end
            i2cm_pkg::OP_WRITE, i2cm_pkg::OP_READ: begin
                if (r_state != i2cm_pkg::ST_IDLE) begin
                    rej = 1'b1;
                end else begin
                    n_dev     = ent.dev_addr;
                    n_reg     = ent.reg_addr;
                    n_data    = ent.wr_data;
                    n_is_read = (ent.op == i2cm_pkg::OP_READ);
                    n_err     = i2cm_pkg::ERR_OK;
                    n_bit     = '0;
                    n_state   = i2cm_pkg::ST_START;
                    n_sub     = 3'd0;
                    n_rep     = 1'b0;
                    n_wait    = '0;
                    n_sda     = 1'b1;
                end
            end
            i2cm_pkg::OP_NOP: ;
        endcase
    end

    // Sequencer registers advance once per popped word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= i2cm_pkg::ST_IDLE;
            r_sub     <= '0;
            r_rep     <= 1'b0;
            r_byte    <= i2cm_pkg::BYTE_DEV;
            r_bit     <= '0;
            r_shift   <= '0;
            r_wait    <= '0;
            r_err     <= i2cm_pkg::ERR_OK;
            r_rxd     <= '0;
            r_is_read <= 1'b0;
            r_dev     <= '0;
            r_reg     <= '0;
            r_data    <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
        end else if (o_pop) begin
            r_state   <= n_state;
            r_sub     <= n_sub;
            r_rep     <= n_rep;
            r_byte    <= n_byte;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_wait    <= n_wait;
            r_err     <= n_err;
            r_rxd     <= n_rxd;
            r_is_read <= n_is_read;
            r_dev     <= n_dev;
            r_reg     <= n_reg;
            r_data    <= n_data;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.scl_out      <= n_scl;
            r_out.sda_out      <= n_sda;
            r_out.busy_res     <= (n_state != i2cm_pkg::ST_IDLE);
            r_out.done_res     <= done;
            r_out.rd_data      <= n_rxd;
            r_out.status       <= n_err;
            r_out.cmd_rejected <= rej;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Checks
    `I2CM_ASSERT_NOW(a_idle_released, r_state == i2cm_pkg::ST_IDLE, r_scl && r_sda,
        "bus lines not released while idle")
    `I2CM_ASSERT_NOW(a_bit_range, 1'b1, r_bit <= i2cm_pkg::BITS_PER_BYTE,
        "bit index past one byte")
    `I2CM_ASSERT_NOW(a_stop_sub, r_state == i2cm_pkg::ST_STOP, r_sub <= 3'd2,
        "stop phase index out of range")
    `I2CM_ASSERT_NEXT(a_cmd_starts,
        o_pop && r_state == i2cm_pkg::ST_IDLE &&
        (ent.op == i2cm_pkg::OP_WRITE || ent.op == i2cm_pkg::OP_READ),
        r_state == i2cm_pkg::ST_START && r_sub == 3'd0 && r_sda,
        "accepted command did not begin a start condition")

endmodule

@@ sv/i2c_master_register_access.sv @@
// Top level: I2C master register access with phase-timing config register
//
//   channel   direction  handshake                   word
//   -------   ---------  --------------------------  ---------------------
//   in        input      i_in_valid / o_in_stall     i_in_word  (t_in_word)
//   out       output     o_out_valid / i_out_stall   o_out_word (t_out_word)
//   config    input      APB psel/penable/pready     phase_ticks at 0x0
//
// One word is accepted per cycle unless the queue is full, giving one result
// word; its result is in the result register on the cycle after it is popped.
// The sequencer handles one queued word per clock, so throughput is set by the
// queue read port: one word per cycle while the result side is not stalled.
// Reset is synchronous, active low; it empties the queue and idles the bus.
// A stalled result holds; the queue (QUEUE_DEPTH words) absorbs input until full.
`timescale 1ns / 1ps

module i2c_master_register_access #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  i2cm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output i2cm_pkg::t_out_word o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [9:0]       r_phase_ticks;
    i2cm_pkg::t_qhead head;
    logic             pop;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
        end else if (psel && penable && pwrite && paddr == i2cm_pkg::ADDR_PHASE_TICKS) begin
            r_phase_ticks <= pwdata[9:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == i2cm_pkg::ADDR_PHASE_TICKS) ? {22'd0, r_phase_ticks} : 32'd0;

    i2cm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_head     (head),
        .i_pop      (pop)
    );

    i2cm_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_phase_ticks (r_phase_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word)
    );

endmodule

@@ test/tb.sv @@
// Testbench for the I2C master register access block: predicted bus levels and status per word
`timescale 1ns / 1ps

module tb;

    // Sequencer steps of the bus transaction
    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_START  = 6'd1;   // four phases
    localparam logic [5:0] S_DEV    = 6'd5;   // five-phase byte send blocks
    localparam logic [5:0] S_REG    = 6'd10;
    localparam logic [5:0] S_DATA   = 6'd15;
    localparam logic [5:0] S_STOP   = 6'd20;  // three phases
    localparam logic [5:0] S_RSTART = 6'd23;  // four phases
    localparam logic [5:0] S_DEV_RD = 6'd27;
    localparam logic [5:0] S_RX_BIT = 6'd32;
    localparam logic [5:0] S_RX_CLK = 6'd33;
    localparam logic [5:0] S_NACK   = 6'd34;  // three phases

    // Phase offsets inside a byte send block
    localparam int BIT_LOW  = 0;
    localparam int BIT_HIGH = 1;
    localparam int BIT_FALL = 2;
    localparam int ACK_REL  = 3;
    localparam int ACK_HIGH = 4;

    localparam logic [1:0] FUNC_NOP = i2cm_pkg::OP_NOP;

    localparam int RANDOM_WORDS    = 200;
    localparam int RST_PHASE_SPAN  = 105;  // crosses one phase at the reset length
    localparam int LONG_PHASE_SPAN = 40;   // part of one phase at the longest length
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_LONG       = 300;
    localparam int CYCLE_LIMIT     = 200_000;

    // How the simulated target drives SDA on tick words
    typedef enum {LINE_CLEAN, LINE_NOISE, LINE_NACK, LINE_LOW, LINE_HIGH} t_line_mode;

    typedef struct packed {
        logic [5:0] step;
        logic [3:0] bit_idx;
        logic [7:0] shift;
        logic [9:0] wait_cnt;
        logic [1:0] first_err;
        logic [7:0] rx_byte;
        logic       is_read;
        logic [7:0] dev;
        logic [7:0] reg_byte;
        logic [7:0] data;
        logic       scl;
        logic       sda;
    } t_seq_state;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    i2cm_pkg::t_in_word  i_in_word   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    i2cm_pkg::t_out_word o_out_word;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [1:0]          paddr       = i2cm_pkg::ADDR_PHASE_TICKS;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    t_seq_state          dut_model;          // advanced as words are accepted
    t_seq_state          gen_model;          // advanced as words are generated
    logic [9:0]          phase_ticks_cfg;
    i2cm_pkg::t_in_word  pending_words[$];
    i2cm_pkg::t_out_word line_state_q[$];
    int                  fail_count    = 0;
    int                  rand_count    = 0;
    bit                  counting      = 1'b0;
    bit                  calm          = 1'b0;
    int                  squeeze_req   = 0;
    int                  squeeze_taken = 0;
    int                  gap_left      = 0;
    int                  hold_left     = 0;
    int                  cycle_cnt     = 0;

    i2c_master_register_access i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic void seq_reset(inout t_seq_state st);
        st = '0;
        st.scl = 1'b1;
        st.sda = 1'b1;
    endfunction

    // Start of the byte send block holding step s, or idle when none
    function automatic logic [5:0] byte_base(input logic [5:0] s);
        if (s >= S_DEV && s <= S_DEV + 4) return S_DEV;
        if (s >= S_REG && s <= S_REG + 4) return S_REG;
        if (s >= S_DATA && s <= S_DATA + 4) return S_DATA;
        if (s >= S_DEV_RD && s <= S_DEV_RD + 4) return S_DEV_RD;
        return S_IDLE;
    endfunction

    function automatic void note_err(inout t_seq_state st, input logic [1:0] code);
        if (st.first_err == i2cm_pkg::ERR_OK) st.first_err = code;
    endfunction

    // Enter a step: line levels are set on entry
    function automatic void go_step(inout t_seq_state st, input logic [5:0] s);
        logic [5:0] base;
        base = byte_base(s);
        st.step = s;
        st.wait_cnt = '0;
        if (base != S_IDLE) begin
            case (s - base)
                BIT_LOW: begin
                    st.scl = 1'b0;
                    st.sda = st.shift[7];
                end
                BIT_HIGH: st.scl = 1'b1;
                BIT_FALL: st.scl = 1'b0;
                ACK_REL:  st.sda = 1'b1;
                default:  st.scl = 1'b1;
            endcase
        end else begin
            case (s)
                S_START, S_RSTART:         st.sda = 1'b1;
                S_START + 1, S_RSTART + 1: st.scl = 1'b1;
                S_START + 2, S_RSTART + 2: st.sda = 1'b0;
                S_START + 3, S_RSTART + 3: st.scl = 1'b0;
                S_RX_BIT: begin
                    st.sda = 1'b1;
                    st.scl = 1'b1;
                end
                S_RX_CLK:   st.scl = 1'b0;
                S_NACK:     st.sda = 1'b1;
                S_NACK + 1: st.scl = 1'b1;
                S_NACK + 2: st.scl = 1'b0;
                S_STOP:     st.sda = 1'b0;
                S_STOP + 1: st.scl = 1'b1;
                S_STOP + 2: st.sda = 1'b1;
                default: ;
            endcase
        end
    endfunction

    // End of a phase; returns 1 when the stop condition completes
    function automatic logic end_phase(inout t_seq_state st, input logic sda_in);
        logic [5:0] s;
        logic [5:0] base;
        logic       done;
        s = st.step;
        base = byte_base(s);
        done = 1'b0;
        if (base != S_IDLE) begin
            if (s - base == BIT_FALL) begin
                st.shift = {st.shift[6:0], 1'b0};
                st.bit_idx = st.bit_idx + 4'd1;
                go_step(st, st.bit_idx < i2cm_pkg::BITS_PER_BYTE ? base
                                                                 : base + 6'(ACK_REL));
            end else if (s - base == ACK_HIGH) begin
                if (sda_in) note_err(st, i2cm_pkg::ERR_NACK);
                st.scl = 1'b0;
                st.bit_idx = '0;
                if (base == S_DEV) begin
                    st.shift = st.reg_byte;
                    go_step(st, S_REG);
                end else if (base == S_REG) begin
                    if (st.is_read) begin
                        go_step(st, S_RSTART);
                    end else begin
                        st.shift = st.data;
                        go_step(st, S_DATA);
                    end
                end else if (base == S_DATA) begin
                    go_step(st, S_STOP);
                end else begin
                    st.shift = '0;
                    go_step(st, S_RX_BIT);
                end
            end else begin
                go_step(st, s + 6'd1);
            end
        end else begin
            case (s)
                S_START + 1, S_RSTART + 1: begin
                    if (!sda_in) note_err(st, i2cm_pkg::ERR_BUSY);
                    go_step(st, s + 6'd1);
                end
                S_START + 3: begin
                    if (sda_in) note_err(st, i2cm_pkg::ERR_BUS);
                    st.shift = st.dev;
                    st.bit_idx = '0;
                    go_step(st, S_DEV);
                end
                S_RSTART + 3: begin
                    if (sda_in) note_err(st, i2cm_pkg::ERR_BUS);
                    st.shift = st.dev + i2cm_pkg::DEV_READ_INC;
                    st.bit_idx = '0;
                    go_step(st, S_DEV_RD);
                end
                S_RX_BIT: begin
                    st.shift = {st.shift[6:0], sda_in};
                    go_step(st, S_RX_CLK);
                end
                S_RX_CLK: begin
                    st.bit_idx = st.bit_idx + 4'd1;
                    if (st.bit_idx < i2cm_pkg::BITS_PER_BYTE) begin
                        go_step(st, S_RX_BIT);
                    end else begin
                        st.rx_byte = st.shift;
                        go_step(st, S_NACK);
                    end
                end
                S_NACK + 2: go_step(st, S_STOP);
                S_STOP + 2: begin
                    st.step = S_IDLE;
                    st.wait_cnt = '0;
                    done = 1'b1;
                end
                default: go_step(st, s + 6'd1);
            endcase
        end
        return done;
    endfunction

    // One input word in, one result word out
    function automatic i2cm_pkg::t_out_word i2c_seq_step(inout t_seq_state st,
                                                         input logic [9:0] ticks,
                                                         input i2cm_pkg::t_in_word w);
        logic [9:0]          lim;
        logic                done;
        logic                rej;
        i2cm_pkg::t_out_word r;
        lim = (ticks == 10'd0) ? 10'd1 : ticks;
        done = 1'b0;
        rej = 1'b0;
        if (w.func == i2cm_pkg::FUNC_TICK) begin
            if (st.step != S_IDLE) begin
                st.wait_cnt = st.wait_cnt + 10'd1;
                if (st.wait_cnt >= lim) done = end_phase(st, w.sda_in);
            end
        end else if (w.func == i2cm_pkg::FUNC_WRITE || w.func == i2cm_pkg::FUNC_READ) begin
            if (st.step != S_IDLE) begin
                rej = 1'b1;
            end else begin
                st.dev = w.dev_addr;
                st.reg_byte = w.reg_addr;
                st.data = w.wr_data;
                st.is_read = (w.func == i2cm_pkg::FUNC_READ);
                st.first_err = i2cm_pkg::ERR_OK;
                st.bit_idx = '0;
                go_step(st, S_START);
            end
        end
        r.scl_out = st.scl;
        r.sda_out = st.sda;
        r.busy_res = (st.step != S_IDLE);
        r.done_res = done;
        r.rd_data = st.rx_byte;
        r.status = st.first_err;
        r.cmd_rejected = rej;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // SDA as seen by the master on the next tick, per target behavior
    function automatic logic line_level(input t_line_mode mode);
        logic [5:0] base;
        base = byte_base(gen_model.step);
        case (mode)
            LINE_LOW:   return 1'b0;
            LINE_HIGH:  return 1'b1;
            LINE_NOISE: return 1'($urandom_range(0, 1));
            default: begin
                if (base != S_IDLE && gen_model.step - base == ACK_HIGH)
                    return (mode == LINE_NACK) || ($urandom_range(0, 19) == 0);
                if (gen_model.step == S_RX_BIT) return 1'($urandom_range(0, 1));
                return gen_model.sda;
            end
        endcase
    endfunction

    task automatic push_word(input logic [1:0] func, input logic [7:0] dev, regv, data,
                             input logic sda);
        i2cm_pkg::t_in_word w;
        w.func = func;
        w.dev_addr = dev;
        w.reg_addr = regv;
        w.wr_data = data;
        w.sda_in = sda;
        // idle ticks and no-ops do not count toward the random budget
        if (counting && (func == i2cm_pkg::FUNC_TICK ? gen_model.step != S_IDLE
                                                     : func != FUNC_NOP))
            rand_count++;
        void'(i2c_seq_step(gen_model, phase_ticks_cfg, w));
        pending_words.push_back(w);
    endtask

    // Tick until the transaction ends, with stray commands mixed in
    task automatic tick_until_idle(input t_line_mode mode, input int stray_pct);
        while (gen_model.step != S_IDLE) begin
            if ($urandom_range(0, 99) < stray_pct)
                push_word(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            else
                push_word(i2cm_pkg::FUNC_TICK, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          line_level(mode));
        end
    endtask

    // A run of ticks that need not finish the transaction
    task automatic tick_span(input int n, input t_line_mode mode);
        repeat (n)
            push_word(i2cm_pkg::FUNC_TICK, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      line_level(mode));
    endtask

    task automatic run_txn(input logic [1:0] func, input logic [7:0] dev, regv, data,
                           input t_line_mode mode, input int stray_pct);
        push_word(func, dev, regv, data, 1'($urandom_range(0, 1)));
        tick_until_idle(mode, stray_pct);
    endtask

    // Wait until every word went through and the block settled; sampled
    // between edges so the driver's and monitor's updates have landed
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || line_state_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write of phase_ticks, then read back
    task automatic set_phase_ticks(input logic [9:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= i2cm_pkg::ADDR_PHASE_TICKS;
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        phase_ticks_cfg = val;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== 32'(val)) begin
            $error("phase_ticks readback: expected %0d, got %0d", val, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_line_mode pick_mode();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 70) return LINE_CLEAN;
        if (p < 80) return LINE_NOISE;
        if (p < 87) return LINE_NACK;
        if (p < 93) return LINE_LOW;
        return LINE_HIGH;
    endfunction

    // ---------------------------------------------------------------- sequence

    initial begin
        logic [9:0] ticks;
        bit         first_phase;
        int         n_idle;
        seq_reset(dut_model);
        seq_reset(gen_model);
        phase_ticks_cfg = i2cm_pkg::PHASE_TICKS_RST;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset phase length: idle words, a write with commands while busy,
        // then ticks across the first phase boundary
        push_word(i2cm_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 1'b0);
        push_word(i2cm_pkg::FUNC_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_word(FUNC_NOP, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_word(i2cm_pkg::FUNC_WRITE, 8'h00, 8'hFF, 8'h00, 1'b0);
        push_word(i2cm_pkg::FUNC_READ, 8'hFF, 8'h00, 8'hFF, 1'b1);
        push_word(i2cm_pkg::FUNC_WRITE, 8'hA5, 8'h5A, 8'hC3, 1'b0);
        push_word(FUNC_NOP, 8'h00, 8'h00, 8'h00, 1'b0);
        tick_span(RST_PHASE_SPAN, LINE_CLEAN);
        wait_idle();

        // Zero phase length behaves as one; the write ends with SDA held low
        set_phase_ticks(10'd0);
        tick_until_idle(LINE_LOW, 0);
        wait_idle();

        // Shortest phase: device address wraps on the read
        set_phase_ticks(10'd1);
        run_txn(i2cm_pkg::FUNC_READ, 8'hFF, 8'h00, 8'h00, LINE_CLEAN, 0);
        wait_idle();

        // Longest phase, part of one phase, no idling on either side
        set_phase_ticks(10'd1023);
        calm = 1'b1;
        push_word(i2cm_pkg::FUNC_WRITE, 8'hA0, 8'h0F, 8'hF0, 1'b0);
        tick_span(LONG_PHASE_SPAN, LINE_CLEAN);
        wait_idle();
        calm = 1'b0;

        // Finish that write at the shortest phase, target never acknowledging
        set_phase_ticks(10'd1);
        tick_until_idle(LINE_NACK, 0);
        wait_idle();

        // Random transactions over short phase lengths
        counting = 1'b1;
        first_phase = 1'b1;
        while (rand_count < RANDOM_WORDS) begin
            case ($urandom_range(0, 5))
                0:       ticks = 10'd0;
                1, 2, 3: ticks = 10'd1;
                4:       ticks = 10'd2;
                default: ticks = 10'd3;
            endcase
            set_phase_ticks(ticks);
            if (first_phase) squeeze_req++;
            first_phase = 1'b0;
            repeat ($urandom_range(2, 3)) begin
                n_idle = $urandom_range(0, 3);
                repeat (n_idle)
                    push_word($urandom_range(0, 1) ? i2cm_pkg::FUNC_TICK : FUNC_NOP,
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                run_txn($urandom_range(0, 1) ? i2cm_pkg::FUNC_READ : i2cm_pkg::FUNC_WRITE,
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), pick_mode(), $urandom_range(0, 4));
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        int unsigned pick;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            // word on the bus (if any) is taken at this edge
            if (i_in_valid)
                line_state_q.push_back(i2c_seq_step(dut_model, phase_ticks_cfg, i_in_word));
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_words.size() != 0) begin
                i_in_word <= pending_words.pop_front();
                i_in_valid <= 1'b1;
                pick = $urandom_range(0, 99);
                if (calm || pick < 50)
                    gap_left <= 0;
                else if (pick < 85)
                    gap_left <= $urandom_range(1, 3);
                else if (pick < 98)
                    gap_left <= $urandom_range(4, 10);
                else
                    gap_left <= $urandom_range(20, 40);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic compare_word(input i2cm_pkg::t_out_word want,
                                input i2cm_pkg::t_out_word got);
        if (got.scl_out !== want.scl_out) begin
            $error("scl_out: expected %0d, got %0d", want.scl_out, got.scl_out);
            fail_count++;
        end
        if (got.sda_out !== want.sda_out) begin
            $error("sda_out: expected %0d, got %0d", want.sda_out, got.sda_out);
            fail_count++;
        end
        if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
            fail_count++;
        end
        if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
            fail_count++;
        end
        if (got.rd_data !== want.rd_data) begin
            $error("rd_data: expected 0x%02h, got 0x%02h", want.rd_data, got.rd_data);
            fail_count++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.cmd_rejected !== want.cmd_rejected) begin
            $error("cmd_rejected: expected %0d, got %0d", want.cmd_rejected, got.cmd_rejected);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        int unsigned pick;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (line_state_q.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    compare_word(line_state_q.pop_front(), o_out_word);
                end
            end
            // long hold-off so the input side backs up
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (squeeze_taken != squeeze_req) begin
                i_out_stall <= 1'b1;
                hold_left <= HOLD_LONG;
                squeeze_taken <= squeeze_req;
            end else if (calm) begin
                i_out_stall <= 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    i_out_stall <= 1'b0;
                end else if (pick < 94) begin
                    i_out_stall <= 1'b1;
                    hold_left <= $urandom_range(0, 2);
                end else if (pick < 99) begin
                    i_out_stall <= 1'b1;
                    hold_left <= $urandom_range(3, 10);
                end else begin
                    i_out_stall <= 1'b1;
                    hold_left <= $urandom_range(20, 40);
                end
            end
        end
    end

    // Hang guard
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
